/* design/dhtr_pkg.sv */
`default_nettype none

package dhtr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int BITCNT_W   = 6;

  localparam logic [2:0] CFG_ENABLE_READS     = 3'd0;
  localparam logic [2:0] CFG_READ_EVERY_CALLS = 3'd1;
  localparam logic [2:0] CFG_START_LOW_US     = 3'd2;
  localparam logic [2:0] CFG_RELEASE_WAIT_US  = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT_US       = 3'd4;

  localparam logic       RST_ENABLE_READS     = 1'b1;
  localparam logic [7:0] RST_READ_EVERY_CALLS = 8'd100;
  localparam logic [13:0] RST_START_LOW_US    = 14'd1100;
  localparam logic [7:0] RST_RELEASE_WAIT_US  = 8'd50;
  localparam logic [13:0] RST_TIMEOUT_US      = 14'd10000;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
  localparam logic [1:0] ERR_CHECKSUM = 2'd2;

  localparam logic [7:0] TEMP_MAG_MASK = 8'h7F;
  localparam logic [7:0] TEMP_SIGN     = 8'h80;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_START_LOW = 7'b0000010,
    PH_RELEASE   = 7'b0000100,
    PH_ACK_LOW   = 7'b0001000,
    PH_ACK_HIGH  = 7'b0010000,
    PH_BIT_LOW   = 7'b0100000,
    PH_BIT_HIGH  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic line_level;
    logic us_tick;
    logic task_tick;
  } in_word_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               result_ready;
    logic               read_ok;
    logic [1:0]         error_code;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;
  } out_word_t;

  typedef struct packed {
    logic        enable_reads;
    logic [7:0]  read_every_calls;
    logic [13:0] start_low_us;
    logic [7:0]  release_wait_us;
    logic [13:0] timeout_us;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* design/dhtr_out_buf.sv */
`default_nettype none

module dhtr_out_buf
  import dhtr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t push_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  out_word_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full output buffer");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && !push) |=> (cnt_r == $past(cnt_r)) && $stable(rd_ptr_r))
    else $error("stalled word lost");

endmodule

`default_nettype wire

/* design/dhtr_core.sv */
`default_nettype none

module dhtr_core
  import dhtr_pkg::*;
#(
  parameter int TIMER_BITS = 14
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  input  wire cfg_regs_t cfg,
  input  wire logic      buf_full,
  output logic           push,
  output out_word_t      res
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  logic     in_v_r;
  in_word_t in_d_r;

  phase_t                  phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]   timer_r, timer_nxt, timer_inc;
  logic [7:0]              cc_r, cc_nxt;
  logic [BITCNT_W-1:0]     bit_r, bit_nxt;
  logic [TIMER_BITS-1:0]   low_r, low_nxt;
  logic [FRAME_BITS-1:0]   frame_r, frame_nxt;
  logic                    to_seen_r, to_seen_nxt;
  logic                    ck_bad_r, ck_bad_nxt;
  logic [15:0]             hum_r, hum_nxt;
  logic [15:0]             temp_r, temp_nxt;
  logic                    ok_r, ok_nxt;

  logic       trigger, ended, want, finish, finish_to;
  logic [7:0] b0, b1, b2, b3, b4, sum;
  logic [14:0] mag;

  assign in_stall = in_v_r && buf_full;
  assign push     = in_v_r && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_d_r <= in_data;
    end
  end

  assign timer_inc = (in_d_r.us_tick && timer_r != TIMER_MAX) ?
                     timer_r + 1'b1 : timer_r;

  assign b0  = frame_nxt[39:32];
  assign b1  = frame_nxt[31:24];
  assign b2  = frame_nxt[23:16];
  assign b3  = frame_nxt[15:8];
  assign b4  = frame_nxt[7:0];
  assign sum = b0 + b1 + b2 + b3;
  assign mag = {b2[6:0] & TEMP_MAG_MASK[6:0], b3};

  always_comb begin
    trigger     = 1'b0;
    ended       = 1'b0;
    finish      = 1'b0;
    finish_to   = 1'b0;
    want        = 1'b0;
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    cc_nxt      = cc_r;
    bit_nxt     = bit_r;
    low_nxt     = low_r;
    frame_nxt   = frame_r;
    to_seen_nxt = to_seen_r;
    ck_bad_nxt  = ck_bad_r;
    hum_nxt     = hum_r;
    temp_nxt    = temp_r;
    ok_nxt      = ok_r;

    if (cfg.enable_reads && in_d_r.task_tick) begin
      if (cc_r <= 8'd1) begin
        cc_nxt  = cfg.read_every_calls;
        trigger = 1'b1;
      end else begin
        cc_nxt = cc_r - 8'd1;
      end
    end

    case (phase_r)
      PH_IDLE: begin
        if (trigger) begin
          phase_nxt = PH_START_LOW;
          timer_nxt = '0;
          bit_nxt   = '0;
          low_nxt   = '0;
          frame_nxt = '0;
        end
      end
      PH_START_LOW: begin
        if (timer_r >= TIMER_BITS'(cfg.start_low_us)) begin
          phase_nxt = PH_RELEASE;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_RELEASE: begin
        if (timer_r >= TIMER_BITS'(cfg.release_wait_us)) begin
          phase_nxt = PH_ACK_LOW;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      PH_ACK_LOW, PH_ACK_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
        want = (phase_r == PH_ACK_HIGH) || (phase_r == PH_BIT_HIGH);
        if (in_d_r.line_level != want) begin
          timer_nxt = '0;
          case (phase_r)
            PH_ACK_LOW:  phase_nxt = PH_ACK_HIGH;
            PH_ACK_HIGH: phase_nxt = PH_BIT_LOW;
            PH_BIT_LOW: begin
              low_nxt   = timer_r;
              phase_nxt = PH_BIT_HIGH;
            end
            default: begin
              frame_nxt = {frame_r[FRAME_BITS-2:0], (timer_r > low_r)};
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = PH_BIT_LOW;
              if (bit_nxt >= BITCNT_W'(FRAME_BITS)) begin
                finish = 1'b1;
              end
            end
          endcase
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= TIMER_BITS'(cfg.timeout_us)) begin
            finish    = 1'b1;
            finish_to = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase

    if (finish) begin
      ended       = 1'b1;
      phase_nxt   = PH_IDLE;
      timer_nxt   = '0;
      to_seen_nxt = finish_to;
      ck_bad_nxt  = !finish_to && (sum != b4);
      if (finish_to || (sum != b4)) begin
        ok_nxt   = 1'b0;
        hum_nxt  = '0;
        temp_nxt = '0;
      end else begin
        ok_nxt  = 1'b1;
        hum_nxt = {b0, b1};
        if ((b2 & TEMP_SIGN) != 8'd0) begin
          temp_nxt = 16'd0 - {1'b0, mag};
        end else begin
          temp_nxt = {1'b0, mag};
        end
      end
    end
  end

  always_comb begin
    res.drive_low          = (phase_nxt == PH_START_LOW);
    res.busy_res           = (phase_nxt != PH_IDLE);
    res.result_ready       = ended;
    res.read_ok            = ok_nxt;
    res.error_code         = to_seen_nxt ? ERR_TIMEOUT :
                             (ck_bad_nxt ? ERR_CHECKSUM : ERR_NONE);
    res.humidity_tenths    = hum_nxt;
    res.temperature_tenths = temp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      cc_r      <= RST_READ_EVERY_CALLS;
      bit_r     <= '0;
      low_r     <= '0;
      frame_r   <= '0;
      to_seen_r <= 1'b0;
      ck_bad_r  <= 1'b0;
      hum_r     <= '0;
      temp_r    <= '0;
      ok_r      <= 1'b0;
    end else if (push) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      cc_r      <= cc_nxt;
      bit_r     <= bit_nxt;
      low_r     <= low_nxt;
      frame_r   <= frame_nxt;
      to_seen_r <= to_seen_nxt;
      ck_bad_r  <= ck_bad_nxt;
      hum_r     <= hum_nxt;
      temp_r    <= temp_nxt;
      ok_r      <= ok_nxt;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (timer_r == '0))
    else $error("timer running while idle");
  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BITCNT_W'(FRAME_BITS))
    else $error("bit counter past frame length");
  a_ready_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.result_ready) |=> (phase_r == PH_IDLE))
    else $error("read ended without returning to idle");

endmodule

`default_nettype wire

/* design/dht22_single_wire_reader.sv */
// Pipeline: input register, then the result buffer that holds result words for out_*.
// Throughput: one input word per cycle, stalled while the result buffer is full.
// A two-entry result buffer lets input words keep entering while a result waits.
// Reset: synchronous on rst_n low; idle phase, countdown 100, defaults in config and core
// state registers, held results cleared and the result buffer emptied.
`default_nettype none

module dht22_single_wire_reader
  import dhtr_pkg::*;
#(
  parameter int TIMER_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  cfg_regs_t cfg_r;
  out_word_t res;
  logic      buf_full, push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_reads     <= RST_ENABLE_READS;
      cfg_r.read_every_calls <= RST_READ_EVERY_CALLS;
      cfg_r.start_low_us     <= RST_START_LOW_US;
      cfg_r.release_wait_us  <= RST_RELEASE_WAIT_US;
      cfg_r.timeout_us       <= RST_TIMEOUT_US;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE_READS:     cfg_r.enable_reads     <= cfg_data[0];
        CFG_READ_EVERY_CALLS: cfg_r.read_every_calls <= cfg_data[7:0];
        CFG_START_LOW_US:     cfg_r.start_low_us     <= cfg_data;
        CFG_RELEASE_WAIT_US:  cfg_r.release_wait_us  <= cfg_data[7:0];
        CFG_TIMEOUT_US:       cfg_r.timeout_us       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dhtr_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .buf_full (buf_full),
    .push     (push),
    .res      (res)
  );

  dhtr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
